// ===== hdl/pti_pkg.sv =====
package pti_pkg;

    localparam int FRAC_BITS = 16;
    localparam int WORD_BITS = 32;
    localparam int ELEM_BITS = 32;
    localparam int OUT_BITS  = (WORD_BITS > ELEM_BITS) ? ELEM_BITS : WORD_BITS;

    // products and sums of up to three triple products
    localparam int PROD_BITS = 98;
    localparam int COF_BITS  = 65;
    localparam int MUL_BITS  = 33;
    localparam int NUM_BITS  =
        ((2 * FRAC_BITS + COF_BITS + 1 > PROD_BITS) ? 2 * FRAC_BITS + COF_BITS + 1
                                                     : PROD_BITS) + 1;
    localparam int QUO_BITS  = OUT_BITS;
    localparam int DSH_BITS  = NUM_BITS + QUO_BITS;
    localparam int KCNT_BITS = $clog2(QUO_BITS + 1);

    localparam int NUM_ELEMS = 9;
    localparam int NUM_SLOTS = 10;
    localparam int IDX_BITS  = 4;
    localparam int PC_BITS   = 5;

    localparam logic [1:0] CMD_ISO = 2'd0;
    localparam logic [1:0] CMD_SIM = 2'd1;
    localparam logic [1:0] CMD_AFF = 2'd2;
    localparam logic [1:0] CMD_HOM = 2'd3;

    localparam logic [PC_BITS-1:0] LEN_HOM    = PC_BITS'(21);
    localparam logic [PC_BITS-1:0] LEN_PLANAR = PC_BITS'(6);
    localparam logic [PC_BITS-1:0] HOM_DET_PC = PC_BITS'(18);
    localparam logic [IDX_BITS-1:0] DET_SLOT  = IDX_BITS'(9);

    localparam logic [OUT_BITS:0] LIM_POS = (OUT_BITS + 1)'((64'd1 << (OUT_BITS - 1)) - 64'd1);
    localparam logic [OUT_BITS:0] LIM_NEG = (OUT_BITS + 1)'(64'd1 << (OUT_BITS - 1));
    localparam logic [ELEM_BITS-1:0] ONE_SAT = (FRAC_BITS >= OUT_BITS - 1)
        ? ELEM_BITS'(LIM_POS) : ELEM_BITS'(64'd1 << FRAC_BITS);

    typedef logic signed [ELEM_BITS-1:0] elem_t;
    typedef logic signed [PROD_BITS-1:0] prod_t;
    typedef logic signed [NUM_BITS-1:0]  num_t;

    typedef struct packed {
        logic [1:0] command;
        logic       full_form;
        elem_t m00;
        elem_t m01;
        elem_t m02;
        elem_t m10;
        elem_t m11;
        elem_t m12;
        elem_t m20;
        elem_t m21;
        elem_t m22;
    } in_item_t;

    typedef struct packed {
        elem_t r00;
        elem_t r01;
        elem_t r02;
        elem_t r10;
        elem_t r11;
        elem_t r12;
        elem_t r20;
        elem_t r21;
        elem_t r22;
        logic  singular;
    } out_item_t;

    typedef struct packed {
        logic [IDX_BITS-1:0] a_idx;
        logic                b_slot;
        logic [IDX_BITS-1:0] b_idx;
        logic                neg;
        logic                first;
        logic                last;
        logic [IDX_BITS-1:0] dst;
    } mac_op_t;

    typedef struct packed {
        num_t [NUM_ELEMS-1:0] num;
        num_t                 den;
        logic                 singular;
        logic                 one22;
    } job_t;

    function automatic logic [1:0] inc3(input logic [1:0] v);
        logic [1:0] r;
        case (v)
            2'd0:    r = 2'd1;
            2'd1:    r = 2'd2;
            default: r = 2'd0;
        endcase
        return r;
    endfunction

    function automatic logic [IDX_BITS-1:0] eidx(input logic [1:0] row, input logic [1:0] col);
        return IDX_BITS'(row) * IDX_BITS'(3) + IDX_BITS'(col);
    endfunction

    function automatic mac_op_t mk(input int a, input logic bs, input int b,
                                   input logic ng, input logic fi, input logic la,
                                   input int d);
        mac_op_t o;
        o.a_idx  = IDX_BITS'(a);
        o.b_slot = bs;
        o.b_idx  = IDX_BITS'(b);
        o.neg    = ng;
        o.first  = fi;
        o.last   = la;
        o.dst    = IDX_BITS'(d);
        return o;
    endfunction

    // multiply-accumulate program: element order m00 m01 m02 m10 .. m22
    function automatic mac_op_t prog_op(input logic [1:0] cmd, input logic [PC_BITS-1:0] pc);
        mac_op_t o;
        logic [3:0] cof;
        logic [1:0] i, j, r1, r2, c1, c2, k;
        o = mk(0, 1'b0, 0, 1'b0, 1'b1, 1'b1, 0);
        cof = pc[4:1];
        i = 2'd0;
        j = 2'd0;
        k = 2'(pc - HOM_DET_PC);
        if (cmd == CMD_HOM) begin
            case (cof)
                4'd0:    begin i = 2'd0; j = 2'd0; end
                4'd1:    begin i = 2'd0; j = 2'd1; end
                4'd2:    begin i = 2'd0; j = 2'd2; end
                4'd3:    begin i = 2'd1; j = 2'd0; end
                4'd4:    begin i = 2'd1; j = 2'd1; end
                4'd5:    begin i = 2'd1; j = 2'd2; end
                4'd6:    begin i = 2'd2; j = 2'd0; end
                4'd7:    begin i = 2'd2; j = 2'd1; end
                default: begin i = 2'd2; j = 2'd2; end
            endcase
            r1 = inc3(i);
            r2 = inc3(r1);
            c1 = inc3(j);
            c2 = inc3(c1);
            if (pc < HOM_DET_PC) begin
                if (!pc[0]) begin
                    o = mk(int'(eidx(r1, c1)), 1'b0, int'(eidx(r2, c2)),
                           1'b0, 1'b1, 1'b0, 0);
                end
                else begin
                    o = mk(int'(eidx(r1, c2)), 1'b0, int'(eidx(r2, c1)),
                           1'b1, 1'b0, 1'b1, int'(cof));
                end
            end
            else begin
                // determinant: row 0 against its cofactors
                o = mk(int'(k), 1'b1, int'(k), 1'b0, k == 2'd0, k == 2'd2, int'(DET_SLOT));
            end
        end
        else if (cmd == CMD_AFF) begin
            case (pc)
                5'd0:    o = mk(0, 1'b0, 4, 1'b0, 1'b1, 1'b0, 0);
                5'd1:    o = mk(1, 1'b0, 3, 1'b1, 1'b0, 1'b1, 0);
                5'd2:    o = mk(4, 1'b0, 2, 1'b0, 1'b1, 1'b0, 1);
                5'd3:    o = mk(1, 1'b0, 5, 1'b1, 1'b0, 1'b1, 1);
                5'd4:    o = mk(0, 1'b0, 5, 1'b0, 1'b1, 1'b0, 2);
                default: o = mk(3, 1'b0, 2, 1'b1, 1'b0, 1'b1, 2);
            endcase
        end
        else begin
            case (pc)
                5'd0:    o = mk(0, 1'b0, 0, 1'b0, 1'b1, 1'b0, 0);
                5'd1:    o = mk(3, 1'b0, 3, 1'b0, 1'b0, 1'b1, 0);
                5'd2:    o = mk(0, 1'b0, 2, 1'b0, 1'b1, 1'b0, 1);
                5'd3:    o = mk(3, 1'b0, 5, 1'b0, 1'b0, 1'b1, 1);
                5'd4:    o = mk(1, 1'b0, 2, 1'b0, 1'b1, 1'b0, 2);
                default: o = mk(4, 1'b0, 5, 1'b0, 1'b0, 1'b1, 2);
            endcase
        end
        return o;
    endfunction

endpackage

// ===== hdl/pti_in_if.sv =====
interface pti_in_if;
    logic               valid;
    logic               ready;
    pti_pkg::in_item_t  data;

    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

// ===== hdl/pti_out_if.sv =====
interface pti_out_if;
    logic               valid;
    logic               ready;
    pti_pkg::out_item_t data;

    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

// ===== hdl/pti_front.sv =====
module pti_front (
    input  logic          clk,
    input  logic          rst_n,
    pti_in_if.sink        item,
    output pti_pkg::job_t job,
    output logic          job_valid,
    input  logic          job_ready
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_ISSUE = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_PUSH  = 2'd3;

    logic [1:0] state_reg, state_next;

    logic               hold_valid_reg;
    pti_pkg::in_item_t  hold_reg;
    pti_pkg::in_item_t  cur_reg;
    logic [pti_pkg::PC_BITS-1:0] pc_reg;
    logic               half_reg;

    logic                              p_valid_reg;
    logic signed [2*pti_pkg::MUL_BITS-1:0] p_reg;
    logic                              p_hi_reg;
    logic                              p_neg_reg;
    logic                              p_first_reg;
    logic                              p_last_reg;
    logic [pti_pkg::IDX_BITS-1:0]      p_dst_reg;

    pti_pkg::prod_t acc_reg;
    pti_pkg::prod_t acc_next;
    pti_pkg::prod_t slot_reg [pti_pkg::NUM_SLOTS];

    pti_pkg::job_t  job_reg;
    pti_pkg::job_t  job_asm;

    pti_pkg::elem_t m [pti_pkg::NUM_ELEMS];
    pti_pkg::mac_op_t op;
    logic [pti_pkg::PC_BITS-1:0] len;
    logic signed [pti_pkg::COF_BITS-1:0] b_full;
    logic signed [pti_pkg::MUL_BITS-1:0] mul_a, mul_b;
    logic signed [2*pti_pkg::MUL_BITS-1:0] mul_p;
    logic issue;
    logic load;

    assign item.ready = !hold_valid_reg;
    assign job        = job_reg;
    assign job_valid  = (state_reg == ST_PUSH);

    assign m[0] = cur_reg.m00;
    assign m[1] = cur_reg.m01;
    assign m[2] = cur_reg.m02;
    assign m[3] = cur_reg.m10;
    assign m[4] = cur_reg.m11;
    assign m[5] = cur_reg.m12;
    assign m[6] = cur_reg.m20;
    assign m[7] = cur_reg.m21;
    assign m[8] = cur_reg.m22;

    assign op    = pti_pkg::prog_op(cur_reg.command, pc_reg);
    assign len   = (cur_reg.command == pti_pkg::CMD_HOM) ? pti_pkg::LEN_HOM
                                                         : pti_pkg::LEN_PLANAR;
    assign issue = (state_reg == ST_ISSUE);
    assign load  = (state_reg == ST_IDLE) && hold_valid_reg;

    always_comb
    begin
        if (op.b_slot)
        begin
            b_full = slot_reg[op.b_idx][pti_pkg::COF_BITS-1:0];
        end
        else
        begin
            b_full = pti_pkg::COF_BITS'(m[op.b_idx]);
        end
        mul_a = pti_pkg::MUL_BITS'(m[op.a_idx]);
        // low chunk unsigned, high chunk signed
        mul_b = half_reg ? b_full[pti_pkg::COF_BITS-1:32] : {1'b0, b_full[31:0]};
        mul_p = mul_a * mul_b;
    end

    always_comb
    begin
        pti_pkg::prod_t ext;
        pti_pkg::prod_t addend;
        ext = pti_pkg::PROD_BITS'(p_reg);
        if (p_hi_reg)
        begin
            ext = ext <<< 32;
        end
        addend = p_neg_reg ? -ext : ext;
        acc_next = (p_first_reg && !p_hi_reg) ? addend : acc_reg + addend;
    end

    // build the nine numerators and the common denominator
    always_comb
    begin
        pti_pkg::num_t a, b, c, d, s1, s2, den;
        a  = pti_pkg::NUM_BITS'(cur_reg.m00);
        b  = pti_pkg::NUM_BITS'(cur_reg.m01);
        c  = pti_pkg::NUM_BITS'(cur_reg.m10);
        d  = pti_pkg::NUM_BITS'(cur_reg.m11);
        s1 = -pti_pkg::num_t'(pti_pkg::NUM_BITS'(slot_reg[1]));
        s2 = -pti_pkg::num_t'(pti_pkg::NUM_BITS'(slot_reg[2]));
        den = pti_pkg::NUM_BITS'(slot_reg[0]);
        job_asm = '0;
        case (cur_reg.command)
            pti_pkg::CMD_ISO:
            begin
                den = pti_pkg::num_t'(1) <<< pti_pkg::FRAC_BITS;
                job_asm.num[0] = a <<< pti_pkg::FRAC_BITS;
                job_asm.num[1] = c <<< pti_pkg::FRAC_BITS;
                job_asm.num[3] = b <<< pti_pkg::FRAC_BITS;
                job_asm.num[4] = d <<< pti_pkg::FRAC_BITS;
                job_asm.num[2] = s1;
                job_asm.num[5] = s2;
            end
            pti_pkg::CMD_SIM:
            begin
                job_asm.num[0] = a <<< (2 * pti_pkg::FRAC_BITS);
                job_asm.num[1] = c <<< (2 * pti_pkg::FRAC_BITS);
                job_asm.num[3] = b <<< (2 * pti_pkg::FRAC_BITS);
                job_asm.num[4] = d <<< (2 * pti_pkg::FRAC_BITS);
                job_asm.num[2] = s1 <<< pti_pkg::FRAC_BITS;
                job_asm.num[5] = s2 <<< pti_pkg::FRAC_BITS;
            end
            pti_pkg::CMD_AFF:
            begin
                job_asm.num[0] = d <<< (2 * pti_pkg::FRAC_BITS);
                job_asm.num[1] = (-b) <<< (2 * pti_pkg::FRAC_BITS);
                job_asm.num[3] = (-c) <<< (2 * pti_pkg::FRAC_BITS);
                job_asm.num[4] = a <<< (2 * pti_pkg::FRAC_BITS);
                job_asm.num[2] = s1 <<< pti_pkg::FRAC_BITS;
                job_asm.num[5] = s2 <<< pti_pkg::FRAC_BITS;
            end
            default:
            begin
                den = pti_pkg::NUM_BITS'(slot_reg[pti_pkg::DET_SLOT]);
                for (int i = 0; i < 3; i++)
                begin
                    for (int j = 0; j < 3; j++)
                    begin
                        // transpose of the cofactor matrix
                        job_asm.num[i*3+j] =
                            pti_pkg::num_t'(pti_pkg::NUM_BITS'(slot_reg[j*3+i]))
                            <<< (2 * pti_pkg::FRAC_BITS);
                    end
                end
            end
        endcase
        job_asm.den      = den;
        job_asm.singular = (cur_reg.command != pti_pkg::CMD_ISO) && (den == '0);
        job_asm.one22    = (cur_reg.command != pti_pkg::CMD_HOM) && cur_reg.full_form;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (hold_valid_reg)
                begin
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE:
            begin
                if (half_reg && (pc_reg == len - pti_pkg::PC_BITS'(1)))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!p_valid_reg)
                begin
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH:
            begin
                if (job_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            hold_valid_reg <= 1'b0;
            p_valid_reg    <= 1'b0;
            pc_reg         <= '0;
            half_reg       <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (item.valid && item.ready)
            begin
                hold_valid_reg <= 1'b1;
            end
            else if (load)
            begin
                hold_valid_reg <= 1'b0;
            end
            p_valid_reg <= issue;
            if (load)
            begin
                pc_reg   <= '0;
                half_reg <= 1'b0;
            end
            else if (issue)
            begin
                half_reg <= !half_reg;
                if (half_reg)
                begin
                    pc_reg <= pc_reg + pti_pkg::PC_BITS'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            hold_reg <= item.data;
        end
        if (load)
        begin
            cur_reg <= hold_reg;
        end
        p_reg       <= mul_p;
        p_hi_reg    <= half_reg;
        p_neg_reg   <= op.neg;
        p_first_reg <= op.first;
        p_last_reg  <= op.last;
        p_dst_reg   <= op.dst;
        if (p_valid_reg)
        begin
            acc_reg <= acc_next;
            if (p_hi_reg && p_last_reg)
            begin
                slot_reg[p_dst_reg] <= acc_next;
            end
        end
        if ((state_reg == ST_DRAIN) && !p_valid_reg)
        begin
            job_reg <= job_asm;
        end
    end

endmodule

// ===== hdl/pti_queue.sv =====
module pti_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  pti_pkg::job_t in_data,
    input  logic          in_valid,
    output logic          in_ready,
    output pti_pkg::job_t out_data,
    output logic          out_valid,
    input  logic          out_ready
);

    pti_pkg::job_t mem_reg [2];
    logic       wptr_reg;
    logic       rptr_reg;
    logic [1:0] count_reg;
    logic       push;
    logic       pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = mem_reg[rptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= !wptr_reg;
            end
            if (pop)
            begin
                rptr_reg <= !rptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wptr_reg] <= in_data;
        end
    end

endmodule

// ===== hdl/pti_back.sv =====
module pti_back (
    input  logic          clk,
    input  logic          rst_n,
    input  pti_pkg::job_t job,
    input  logic          job_valid,
    output logic          job_ready,
    pti_out_if.source     result
);

    localparam logic [2:0] BS_IDLE   = 3'd0;
    localparam logic [2:0] BS_LOAD   = 3'd1;
    localparam logic [2:0] BS_STEP   = 3'd2;
    localparam logic [2:0] BS_ROUND  = 3'd3;
    localparam logic [2:0] BS_FINISH = 3'd4;

    localparam logic [pti_pkg::IDX_BITS-1:0] LAST_ELEM = pti_pkg::IDX_BITS'(8);

    logic [2:0] state_reg;
    pti_pkg::job_t job_reg;
    logic [pti_pkg::IDX_BITS-1:0]  elem_reg;
    logic [pti_pkg::NUM_BITS-1:0]  rem_reg;
    logic [pti_pkg::NUM_BITS-1:0]  ud_reg;
    logic [pti_pkg::DSH_BITS-1:0]  dsh_reg;
    logic [pti_pkg::QUO_BITS-1:0]  q_reg;
    logic [pti_pkg::KCNT_BITS-1:0] k_reg;
    logic                          ovf_reg;
    logic                          neg_reg;
    pti_pkg::elem_t                res_reg [pti_pkg::NUM_ELEMS];
    logic                          sing_reg;
    logic                          out_valid_reg;
    pti_pkg::out_item_t            out_reg;

    pti_pkg::num_t                 n_cur;
    logic [pti_pkg::NUM_BITS-1:0]  un;
    logic [pti_pkg::NUM_BITS-1:0]  ud;
    logic                          ge;
    logic                          rnd;
    logic [pti_pkg::QUO_BITS:0]    mag;
    logic [pti_pkg::QUO_BITS:0]    lim;
    logic [pti_pkg::QUO_BITS:0]    sel;
    logic [pti_pkg::ELEM_BITS:0]   selx;
    pti_pkg::elem_t                rval;
    logic                          out_free;

    assign job_ready     = (state_reg == BS_IDLE);
    assign result.valid  = out_valid_reg;
    assign result.data   = out_reg;
    assign out_free      = !out_valid_reg || result.ready;

    always_comb
    begin
        n_cur = job_reg.num[elem_reg];
        un    = n_cur[pti_pkg::NUM_BITS-1] ? pti_pkg::NUM_BITS'(-n_cur)
                                           : pti_pkg::NUM_BITS'(n_cur);
        ud    = job_reg.den[pti_pkg::NUM_BITS-1] ? pti_pkg::NUM_BITS'(-job_reg.den)
                                                 : pti_pkg::NUM_BITS'(job_reg.den);
        ge    = pti_pkg::DSH_BITS'(rem_reg) >= dsh_reg;
        // round half away from zero: twice the remainder against the divisor
        rnd   = {rem_reg, 1'b0} >= {1'b0, ud_reg};
        mag   = (pti_pkg::QUO_BITS + 1)'(q_reg) + (pti_pkg::QUO_BITS + 1)'(rnd);
        lim   = neg_reg ? pti_pkg::LIM_NEG : pti_pkg::LIM_POS;
        sel   = (ovf_reg || (mag > lim)) ? lim : mag;
        selx  = (pti_pkg::ELEM_BITS + 1)'(sel);
        rval  = neg_reg ? pti_pkg::ELEM_BITS'(-selx) : pti_pkg::ELEM_BITS'(selx);
        if (job_reg.one22 && (elem_reg == LAST_ELEM))
        begin
            rval = pti_pkg::ONE_SAT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BS_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                BS_IDLE:
                begin
                    if (job_valid)
                    begin
                        state_reg <= job.singular ? BS_FINISH : BS_LOAD;
                    end
                end
                BS_LOAD:
                begin
                    state_reg <= BS_STEP;
                end
                BS_STEP:
                begin
                    if (k_reg == '0)
                    begin
                        state_reg <= BS_ROUND;
                    end
                end
                BS_ROUND:
                begin
                    state_reg <= (elem_reg == LAST_ELEM) ? BS_FINISH : BS_LOAD;
                end
                BS_FINISH:
                begin
                    if (out_free)
                    begin
                        state_reg <= BS_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= BS_IDLE;
                end
            endcase
            if ((state_reg == BS_FINISH) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            BS_IDLE:
            begin
                job_reg  <= job;
                sing_reg <= job.singular;
                elem_reg <= '0;
                if (job.singular)
                begin
                    for (int i = 0; i < pti_pkg::NUM_ELEMS; i++)
                    begin
                        res_reg[i] <= '0;
                    end
                end
            end
            BS_LOAD:
            begin
                rem_reg <= un;
                ud_reg  <= ud;
                dsh_reg <= pti_pkg::DSH_BITS'(ud) << pti_pkg::QUO_BITS;
                q_reg   <= '0;
                k_reg   <= pti_pkg::KCNT_BITS'(pti_pkg::QUO_BITS);
                ovf_reg <= 1'b0;
                neg_reg <= n_cur[pti_pkg::NUM_BITS-1] != job_reg.den[pti_pkg::NUM_BITS-1];
            end
            BS_STEP:
            begin
                if (k_reg == pti_pkg::KCNT_BITS'(pti_pkg::QUO_BITS))
                begin
                    // quotient would not fit the result word
                    ovf_reg <= ge;
                end
                else
                begin
                    q_reg <= {q_reg[pti_pkg::QUO_BITS-2:0], ge};
                    if (ge)
                    begin
                        rem_reg <= rem_reg - dsh_reg[pti_pkg::NUM_BITS-1:0];
                    end
                end
                dsh_reg <= dsh_reg >> 1;
                k_reg   <= k_reg - pti_pkg::KCNT_BITS'(1);
            end
            BS_ROUND:
            begin
                res_reg[elem_reg] <= rval;
                elem_reg <= elem_reg + pti_pkg::IDX_BITS'(1);
            end
            default:
            begin
                if ((state_reg == BS_FINISH) && out_free)
                begin
                    out_reg.r00      <= res_reg[0];
                    out_reg.r01      <= res_reg[1];
                    out_reg.r02      <= res_reg[2];
                    out_reg.r10      <= res_reg[3];
                    out_reg.r11      <= res_reg[4];
                    out_reg.r12      <= res_reg[5];
                    out_reg.r20      <= res_reg[6];
                    out_reg.r21      <= res_reg[7];
                    out_reg.r22      <= res_reg[8];
                    out_reg.singular <= sing_reg;
                end
            end
        endcase
    end

endmodule

// ===== hdl/planar_transform_inverter_core.sv =====
// channel  | role | handshake     | payload
// item     | in   | valid / ready | command, full_form, m00 .. m22
// result   | out  | valid / ready | r00 .. r22, singular
//
// the front feeds each multiply-accumulate term to one 33x33 multiplier as a low half
// and a high half, over the command's program, then drains and hands off the job
// the back runs one shared restoring divider, one quotient bit a cycle:
// per element a load, an overflow check, one step per quotient bit and a round;
// a singular matrix skips the divider; the divider sets the sustained item rate
// rst_n clears all control state at once; a stalled result holds in the output register
// while the front and a two-entry queue keep taking new items until they fill
module planar_transform_inverter_core (
    input  logic      clk,
    input  logic      rst_n,
    pti_in_if.sink    item,
    pti_out_if.source result
);

    pti_pkg::job_t f_job;
    logic          f_valid;
    logic          f_ready;
    pti_pkg::job_t b_job;
    logic          b_valid;
    logic          b_ready;

    pti_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .job       (f_job),
        .job_valid (f_valid),
        .job_ready (f_ready)
    );

    pti_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (f_job),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .out_data  (b_job),
        .out_valid (b_valid),
        .out_ready (b_ready)
    );

    pti_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job       (b_job),
        .job_valid (b_valid),
        .job_ready (b_ready),
        .result    (result)
    );

    a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.data.singular |->
            result.data.r00 == '0 && result.data.r11 == '0 &&
            result.data.r02 == '0 && result.data.r22 == '0)
        else $error("singular result carries nonzero elements");

    a_singular_den: assert property (@(posedge clk) disable iff (!rst_n)
        f_valid |-> f_job.singular == (f_job.den == '0))
        else $error("singular flag disagrees with denominator");

    a_queue_den: assert property (@(posedge clk) disable iff (!rst_n)
        b_valid && !b_job.singular |-> b_job.den != '0)
        else $error("zero divisor reaches divider");

endmodule
